@@ sv/itp_pkg.sv @@
package itp_pkg;

  // operator codes held in the stack cells
  localparam logic [2:0] CODE_NONE  = 3'd0;
  localparam logic [2:0] CODE_OPEN  = 3'd1;
  localparam logic [2:0] CODE_ADD   = 3'd2;
  localparam logic [2:0] CODE_SUB   = 3'd3;
  localparam logic [2:0] CODE_MUL   = 3'd4;
  localparam logic [2:0] CODE_DIV   = 3'd5;

  // ascii characters of interest
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_UNMATCHED  = 2'd2;

  // shift control for the stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

  // one result before the run flags are known
  typedef struct packed {
    logic [7:0] sym;
    logic [1:0] status;
  } res_t;

  function automatic logic [2:0] char_to_code(input logic [7:0] c);
    logic [2:0] code;
    case (c)
      CH_OPEN: code = CODE_OPEN;
      CH_ADD:  code = CODE_ADD;
      CH_SUB:  code = CODE_SUB;
      CH_MUL:  code = CODE_MUL;
      CH_DIV:  code = CODE_DIV;
      default: code = CODE_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] code_to_char(input logic [2:0] code);
    logic [7:0] c;
    case (code)
      CODE_OPEN: c = CH_OPEN;
      CODE_ADD:  c = CH_ADD;
      CODE_SUB:  c = CH_SUB;
      CODE_MUL:  c = CH_MUL;
      CODE_DIV:  c = CH_DIV;
      default:   c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] code_prio(input logic [2:0] code);
    logic [1:0] p;
    case (code)
      CODE_OPEN: p = 2'd3;
      CODE_ADD:  p = 2'd1;
      CODE_SUB:  p = 2'd1;
      CODE_MUL:  p = 2'd2;
      CODE_DIV:  p = 2'd2;
      default:   p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/itp_cell.sv @@
module itp_cell (
  input  logic             clk,
  input  itp_pkg::stk_op_t op,
  input  logic [2:0]       from_up,
  input  logic [2:0]       from_down,
  output logic [2:0]       code
);
  import itp_pkg::*;

  // push moves entries away from the top, pop moves them towards it
  always_ff @(posedge clk) begin
    if (op.push) begin
      code <= from_up;
    end else if (op.pop) begin
      code <= from_down;
    end
  end

endmodule

@@ sv/infix_to_postfix_converter_unit.sv @@
// each accepted character runs through EXEC, then CLOSE or OPER for brackets and operators,
//   then FLUSH when end_of_expr is set, then FIN; a new character is taken only when idle
// a result waits in a one-result hold and is registered to the output at the next result or FIN;
//   CLOSE, OPER and FLUSH pop one entry per step; a held output register stalls every step
// the operator stack is a chain of cells that shifts by one place per push or pop
// reset (rst, synchronous, active high) clears the state machine, fill count and output valids
module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic       s_axis_tlast,   // end_of_expr
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_symbol
  output logic       m_axis_tlast,   // last_of_run
  output logic [2:0] m_axis_tuser    // [0] expr_complete, [2:1] status
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_CLOSE = 3'd2;
  localparam logic [2:0] S_OPER  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [7:0]    cur_sym;
  logic          cur_last;
  logic [2:0]    cur_code;
  logic [1:0]    cur_prio;
  logic          pend_valid, pend_valid_next;
  res_t          pend, pend_next;
  logic          emit;
  res_t          emit_res;
  logic          fin;
  logic          out_free;
  stk_op_t       sop;
  logic [2:0]    stack_code [STACK_DEPTH];
  logic [2:0]    top_code;
  logic          st_empty, st_full;
  logic [2:0]    after_step;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign top_code      = stack_code[0];
  assign st_empty      = (count == '0);
  assign st_full       = (count >= DEPTH_C);
  assign after_step    = cur_last ? S_FLUSH : S_FIN;

  // chain of stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [2:0] up, down;
    if (i == 0) begin : g_top
      assign up = cur_code;
    end else begin : g_mid
      assign up = stack_code[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down = CODE_NONE;
    end else begin : g_low
      assign down = stack_code[i+1];
    end
    itp_cell u_cell (
      .clk      (clk),
      .op       (sop),
      .from_up  (up),
      .from_down(down),
      .code     (stack_code[i])
    );
  end

  // sequencer: one stack action and at most one result per cycle
  always_comb begin
    state_next = state;
    count_next = count;
    sop        = '0;
    emit       = 1'b0;
    emit_res   = '{sym: CH_NUL, status: ST_OK};
    fin        = 1'b0;
    if (out_free) begin
      case (state)
        S_EXEC: begin
          if (cur_sym == CH_SPACE) begin
            state_next = after_step;
          end else if (cur_sym == CH_CLOSE) begin
            state_next = S_CLOSE;
          end else if (cur_code == CODE_OPEN) begin
            if (st_full) begin
              emit     = 1'b1;
              emit_res = '{sym: cur_sym, status: ST_OVERFLOW};
            end else begin
              sop.push   = 1'b1;
              count_next = count + ONE_C;
            end
            state_next = after_step;
          end else if (cur_code != CODE_NONE) begin
            state_next = S_OPER;
          end else begin
            emit       = 1'b1;
            emit_res   = '{sym: cur_sym, status: ST_OK};
            state_next = after_step;
          end
        end
        S_CLOSE: begin
          if (st_empty) begin
            emit       = 1'b1;
            emit_res   = '{sym: CH_CLOSE, status: ST_UNMATCHED};
            state_next = after_step;
          end else begin
            sop.pop    = 1'b1;
            count_next = count - ONE_C;
            if (top_code == CODE_OPEN) begin
              state_next = after_step;
            end else begin
              emit     = 1'b1;
              emit_res = '{sym: code_to_char(top_code), status: ST_OK};
            end
          end
        end
        S_OPER: begin
          if (!st_empty && top_code != CODE_OPEN && code_prio(top_code) >= cur_prio) begin
            sop.pop    = 1'b1;
            count_next = count - ONE_C;
            emit       = 1'b1;
            emit_res   = '{sym: code_to_char(top_code), status: ST_OK};
          end else begin
            if (st_full) begin
              emit     = 1'b1;
              emit_res = '{sym: cur_sym, status: ST_OVERFLOW};
            end else begin
              sop.push   = 1'b1;
              count_next = count + ONE_C;
            end
            state_next = after_step;
          end
        end
        S_FLUSH: begin
          if (!st_empty) begin
            sop.pop    = 1'b1;
            count_next = count - ONE_C;
            emit       = 1'b1;
            emit_res   = '{sym: code_to_char(top_code), status: ST_OK};
          end else begin
            // empty flush with nothing emitted still needs a result
            if (!pend_valid) begin
              emit     = 1'b1;
              emit_res = '{sym: CH_NUL, status: ST_OK};
            end
            state_next = S_FIN;
          end
        end
        S_FIN: begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
        default: begin
          state_next = S_IDLE;
        end
      endcase
    end
  end

  // one-result hold so the last result of a run can be marked
  always_comb begin
    pend_valid_next = pend_valid;
    pend_next       = pend;
    if (emit) begin
      pend_valid_next = 1'b1;
      pend_next       = emit_res;
    end else if (fin) begin
      pend_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= (s_axis_tvalid && s_axis_tready) ? S_EXEC : state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  // input item and pending result payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cur_sym  <= s_axis_tdata;
      cur_last <= s_axis_tlast;
      cur_code <= char_to_code(s_axis_tdata);
      cur_prio <= code_prio(char_to_code(s_axis_tdata));
    end
    pend <= pend_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((emit || fin) && pend_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((emit || fin) && pend_valid) begin
      m_axis_tdata <= pend.sym;
      m_axis_tlast <= fin;
      m_axis_tuser <= {pend.status, fin && cur_last};
    end
  end

endmodule

@@ tb/infix_to_postfix_converter_unit_tb.sv @@
module infix_to_postfix_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int DEPTH       = 32;
  localparam int RUN_LIMIT   = 300000;
  localparam int DRAIN       = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 100;
  localparam int STIM_TARGET = 360;

  // one infix character as offered to the block
  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
  } infix_t;

  // one postfix character as it should leave the block
  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       expr_end;
    logic [1:0] st;
  } postfix_t;

  // receiver stall behaviour
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_ALTERNATE, RX_SPARSE} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] symbol
  logic       s_axis_tlast = 1'b0;   // end_of_expr
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_symbol
  logic       m_axis_tlast;          // last_of_run
  logic [2:0] m_axis_tuser;          // [0] expr_complete, [2:1] status

  infix_t   infix_q[$];
  postfix_t postfix_q[$];
  infix_t   next_sym;
  postfix_t want;

  // private copy of the operator stack
  logic [2:0] opstack [DEPTH];
  int         depth_used = 0;
  logic [7:0] glyph_of [8] = '{CH_NUL, CH_OPEN, CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_NUL, CH_NUL};
  int         rank_of [8]  = '{0, 3, 1, 1, 2, 2, 0, 0};

  int       stim_count = 0;
  int       accepted_count = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       phase_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic add_postfix(input logic [7:0] ch, input logic [1:0] st, inout int n);
    postfix_t r;
    r.ch       = ch;
    r.run_end  = 1'b0;
    r.expr_end = 1'b0;
    r.st       = st;
    postfix_q.push_back(r);
    n++;
  endtask

  // shunting-yard step for one accepted character
  task automatic convert_symbol(input logic [7:0] ch, input logic eoe);
    logic [2:0] code;
    logic [2:0] top;
    postfix_t   tail;
    int         n;
    bit         matched;
    n = 0;
    matched = 1'b0;
    case (ch)
      CH_OPEN: code = CODE_OPEN;
      CH_ADD:  code = CODE_ADD;
      CH_SUB:  code = CODE_SUB;
      CH_MUL:  code = CODE_MUL;
      CH_DIV:  code = CODE_DIV;
      default: code = CODE_NONE;
    endcase
    if (ch == CH_SPACE) begin
      // skipped
    end else if (ch == CH_CLOSE) begin
      // pop down to the matching open bracket
      while (depth_used > 0 && !matched) begin
        depth_used--;
        top = opstack[depth_used];
        if (top == CODE_OPEN) begin
          matched = 1'b1;
        end else begin
          add_postfix(glyph_of[top], ST_OK, n);
        end
      end
      if (!matched) begin
        add_postfix(CH_CLOSE, ST_UNMATCHED, n);
      end
    end else if (code != CODE_NONE) begin
      // operators first pop anything of equal or higher rank down to an open bracket
      if (code != CODE_OPEN) begin
        while (depth_used > 0 && opstack[depth_used-1] != CODE_OPEN &&
               rank_of[opstack[depth_used-1]] >= rank_of[code]) begin
          depth_used--;
          add_postfix(glyph_of[opstack[depth_used]], ST_OK, n);
        end
      end
      if (depth_used >= DEPTH) begin
        add_postfix(ch, ST_OVERFLOW, n);
      end else begin
        opstack[depth_used] = code;
        depth_used++;
      end
    end else begin
      add_postfix(ch, ST_OK, n);
    end
    // end of expression empties the whole stack
    if (eoe) begin
      while (depth_used > 0) begin
        depth_used--;
        add_postfix(glyph_of[opstack[depth_used]], ST_OK, n);
      end
      if (n == 0) begin
        add_postfix(CH_NUL, ST_OK, n);
      end
    end
    if (n > 0) begin
      tail = postfix_q.pop_back();
      tail.run_end  = 1'b1;
      tail.expr_end = eoe;
      postfix_q.push_back(tail);
    end
  endtask

  task automatic put_symbol(input logic [7:0] ch, input logic eoe);
    infix_t it;
    it.ch  = ch;
    it.eoe = eoe;
    infix_q.push_back(it);
    stim_count++;
  endtask

  task automatic mark_end();
    infix_t it;
    it = infix_q.pop_back();
    it.eoe = 1'b1;
    infix_q.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_symbol(s[i], 1'b0);
    end
    mark_end();
  endtask

  function automatic bit is_special(input logic [7:0] c);
    return c == CH_OPEN || c == CH_CLOSE || c == CH_ADD || c == CH_SUB ||
           c == CH_MUL || c == CH_DIV || c == CH_SPACE;
  endfunction

  function automatic logic [7:0] operand_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 1) == 0) begin
        c = 8'($urandom_range(8'h61, 8'h7A));
      end else begin
        c = 8'($urandom_range(0, 255));
      end
    end while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] operator_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CH_ADD;
      1:       c = CH_SUB;
      2:       c = CH_MUL;
      default: c = CH_DIV;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] special_char();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0:       c = CH_OPEN;
      1:       c = CH_CLOSE;
      2:       c = CH_SPACE;
      default: c = operator_char();
    endcase
    return c;
  endfunction

  // well-formed expression with random operands, brackets and spaces
  task automatic gen_expression(input int terms, input int max_nest);
    int nest;
    int made;
    bit want_operand;
    nest = 0;
    made = 0;
    want_operand = 1'b1;
    while (1'b1) begin
      if ($urandom_range(0, 9) == 0) begin
        put_symbol(CH_SPACE, 1'b0);
      end
      if (want_operand) begin
        if (nest < max_nest && $urandom_range(0, 3) == 0) begin
          put_symbol(CH_OPEN, 1'b0);
          nest++;
        end else begin
          put_symbol(operand_char(), 1'b0);
          want_operand = 1'b0;
          made++;
        end
      end else if (nest > 0 && $urandom_range(0, 2) == 0) begin
        put_symbol(CH_CLOSE, 1'b0);
        nest--;
      end else if (made >= terms) begin
        break;
      end else begin
        put_symbol(operator_char(), 1'b0);
        want_operand = 1'b1;
      end
    end
    repeat (nest) put_symbol(CH_CLOSE, 1'b0);
    mark_end();
  endtask

  // nesting around the stack depth so that pushes overflow
  task automatic gen_deep_nest();
    int opens;
    opens = $urandom_range(DEPTH - 3, DEPTH + 4);
    for (int i = 0; i < opens; i++) begin
      put_symbol(CH_OPEN, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        put_symbol(operand_char(), 1'b0);
        put_symbol(operator_char(), 1'b0);
      end
    end
    put_symbol(operand_char(), 1'b0);
    repeat ($urandom_range(2, 5)) begin
      put_symbol(operator_char(), 1'b0);
      put_symbol(operand_char(), 1'b0);
    end
    repeat ($urandom_range(0, opens + 2)) put_symbol(CH_CLOSE, 1'b0);
    mark_end();
  endtask

  // any byte, end flag at random
  task automatic gen_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1) == 0) begin
        put_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end else begin
        put_symbol(special_char(), $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // bracket and operator soup, stray closes included
  task automatic gen_broken();
    repeat ($urandom_range(2, 10)) begin
      if ($urandom_range(0, 3) == 0) begin
        put_symbol(operand_char(), 1'b0);
      end else begin
        put_symbol(special_char(), 1'b0);
      end
    end
    mark_end();
  endtask

  // stimulus, reset and end of run
  initial begin
    int pick;
    // precedence, left association, brackets and spaces
    put_text("a+b*c-d/e");
    put_text("(x - y)/z");
    // byte extremes as operands
    put_symbol(8'h00, 1'b0);
    put_symbol(CH_MUL, 1'b0);
    put_symbol(8'hFF, 1'b1);
    // close bracket with no open one, then a flush with nothing left
    put_text("p+)");
    put_text(" ");
    // stray open bracket flushed at the end
    put_text("(");
    // bracket pair that only pops its own open bracket
    put_text("()q");
    gen_deep_nest();
    while (stim_count < STIM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        gen_expression($urandom_range(1, 8), $urandom_range(0, 4));
      end else if (pick < 72) begin
        gen_deep_nest();
      end else if (pick < 86) begin
        gen_noise();
      end else begin
        gen_broken();
      end
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (infix_q.size() > 0 || s_axis_tvalid || postfix_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && postfix_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // sender: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        convert_symbol(s_axis_tdata, s_axis_tlast);
        accepted_count <= accepted_count + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (infix_q.size() > 0) begin
          next_sym = infix_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_sym.ch;
          s_axis_tlast  <= next_sym.eoe;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_done     <= 1'b0;
      phase_left    <= 0;
      rx_mode       <= RX_OPEN;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        rx_mode    <= rx_mode_t'($urandom_range(0, 3));
        phase_left <= $urandom_range(16, 96);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (rx_mode)
        RX_OPEN:      m_axis_tready <= 1'b1;
        RX_MOSTLY:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_ALTERNATE: m_axis_tready <= ~m_axis_tready;
        default:      m_axis_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // compare every output transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (postfix_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %02h", m_axis_tdata));
      end else begin
        want = postfix_q.pop_front();
        if (m_axis_tdata !== want.ch) begin
          flag_mismatch($sformatf("out_symbol %02h, want %02h", m_axis_tdata, want.ch));
        end
        if (m_axis_tlast !== want.run_end) begin
          flag_mismatch($sformatf("last_of_run %b, want %b on %02h",
                                  m_axis_tlast, want.run_end, want.ch));
        end
        if (m_axis_tuser[0] !== want.expr_end) begin
          flag_mismatch($sformatf("expr_complete %b, want %b on %02h",
                                  m_axis_tuser[0], want.expr_end, want.ch));
        end
        if (m_axis_tuser[2:1] !== want.st) begin
          flag_mismatch($sformatf("status %0d, want %0d on %02h",
                                  m_axis_tuser[2:1], want.st, want.ch));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

@@ infix_to_postfix_converter_unit.f @@
sv/itp_pkg.sv
sv/itp_cell.sv
sv/infix_to_postfix_converter_unit.sv
tb/infix_to_postfix_converter_unit_tb.sv
